/* sv/rau_pkg.sv */
// ============================================================================
// rau_pkg - shared types and codes for the rational arithmetic unit
// Request and response payloads, opcodes, status codes and sequencer states.
// ============================================================================
package rau_pkg;

    // Default operand width; operands use the low RAU_WIDTH bits of each field
    localparam int RAU_WIDTH = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_REDUCE = 3'd4,
        OP_EQUAL  = 3'd5
    } opcode_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_CHECK,
        S_TWOS,
        S_UODD,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN
    } fsm_state_t;

    typedef struct packed {
        logic        [2:0]  opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic        [30:0] res_den;
        logic               is_equal;
        logic        [1:0]  status;
    } rsp_t;

endpackage

/* sv/rau_alu.sv */
// ============================================================================
// rau_alu - shared adder/subtractor
// Adds or subtracts two unsigned words; carry out high on subtract means
// no borrow, i.e. a >= b.
// ============================================================================
module rau_alu #(
    parameter int AW = 65
) (
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    input  logic          sub,
    output logic [AW-1:0] sum,
    output logic          cout
);

    logic [AW:0] full;

    assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (AW+1)'(sub);
    assign sum  = full[AW-1:0];
    assign cout = full[AW];

endmodule

/* sv/rational_arith_unit_core.sv */
// ============================================================================
// rational_arith_unit_core - fraction arithmetic with GCD reduction
// Add, subtract, multiply, divide, reduce or compare two signed fractions,
// returning arithmetic results reduced and with a non-negative denominator.
// ============================================================================
// Usage:
//   Raise start with a request on req. The request is taken at a rising edge
//   where start is high and busy is low; for arithmetic opcodes busy
//   then stays high until the sequencer is finished. The response
//   appears on rsp with done high for exactly one cycle; the receiver
//   cannot stall, so capture it then. Equal and unused opcodes respond
//   in the cycle after the request. Arithmetic opcodes run on one shared
//   2*WIDTH+1 bit adder/subtractor and one WIDTH x WIDTH multiplier:
//     multiply for the first numerator term, the second term and the
//       denominator, add or subtract (swapping first when needed), check,
//     binary GCD: common factors of two first, then shifts, subtracts and
//       swaps,
//     two restoring divisions of 2*WIDTH quotient bits each, then finish.
//   A zero numerator or denominator skips the GCD and the divisions and
//   responds straight after the check state.
//   The GCD and the bit-serial divisions through the shared subtractor take
//   most of an arithmetic request's time. busy drops in the cycle that done
//   rises, so a new request may follow. Reset returns the sequencer to idle;
//   no response is pending.
// ============================================================================
module rational_arith_unit_core #(
    parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rau_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output rau_pkg::rsp_t rsp
);

    localparam int DW    = 2 * WIDTH;     // double-width magnitudes
    localparam int AW    = DW + 1;        // shared unit width
    localparam int CNT_W = $clog2(DW);
    localparam logic [DW-1:0]    HALF = DW'(1) << (WIDTH - 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

    // Sequencer and operand registers
    rau_pkg::fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [2:0]          op_reg, op_next;
    logic [WIDTH-1:0]    an_reg, an_next, ad_reg, ad_next;
    logic [WIDTH-1:0]    bn_reg, bn_next, bd_reg, bd_next;
    logic                an_neg_reg, an_neg_next, ad_neg_reg, ad_neg_next;
    logic                bn_neg_reg, bn_neg_next, bd_neg_reg, bd_neg_next;

    // Working registers: n/d hold the fraction, t the second numerator term
    // and later the reduced numerator, u/v the GCD pair, q/rem the divider.
    logic [DW-1:0] n_reg, n_next, d_reg, d_next, t_reg, t_next;
    logic          n_neg_reg, n_neg_next, d_neg_reg, d_neg_next;
    logic          t_neg_reg, t_neg_next;
    logic [DW-1:0] u_reg, u_next, v_reg, v_next;
    logic [DW-1:0] q_reg, q_next, rem_reg, rem_next;

    rau_pkg::rsp_t rsp_reg, rsp_next;
    logic          done_reg, done_next;

    // Multiplier operands
    logic [WIDTH-1:0] mx_mag, my_mag;
    logic             mx_neg, my_neg;
    logic [DW-1:0]    prod;
    logic             prod_neg;

    // Shared unit
    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_cout;

    // Input decode
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             in_an_neg, in_ad_neg, in_bn_neg, in_bd_neg;
    logic             in_equal;

    // Divider step
    logic [DW-1:0] q_shift, rem_step;

    // Final range check
    logic                    res_neg, rd_big, rn_big, rn_over;
    logic signed [WIDTH-1:0] num_w;

    function automatic logic [WIDTH-1:0] take_mag(input logic [31:0] field);
        logic [WIDTH-1:0] v;
        v = field[WIDTH-1:0];
        return v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    assign in_an     = take_mag(req.a_num);
    assign in_ad     = take_mag(req.a_den);
    assign in_bn     = take_mag(req.b_num);
    assign in_bd     = take_mag(req.b_den);
    assign in_an_neg = req.a_num[WIDTH-1];
    assign in_ad_neg = req.a_den[WIDTH-1];
    // subtract is add with the sign of b's numerator turned over
    assign in_bn_neg = req.b_num[WIDTH-1] ^ (req.opcode == rau_pkg::OP_SUB);
    assign in_bd_neg = req.b_den[WIDTH-1];
    assign in_equal  = (req.a_num[WIDTH-1:0] == req.b_num[WIDTH-1:0])
                    && (req.a_den[WIDTH-1:0] == req.b_den[WIDTH-1:0]);

    // ------------------------------------------------------------------------
    // Multiplier operand selection. Step 0 forms the first numerator term,
    // step 1 the second (zero outside add and subtract), step 2 the
    // denominator. Reduce multiplies by one.
    // ------------------------------------------------------------------------
    always_comb
    begin
        mx_mag = an_reg;
        mx_neg = an_neg_reg;
        my_mag = bd_reg;
        my_neg = bd_neg_reg;
        unique case (cnt_reg[1:0])
            2'd0:
            begin
                mx_mag = an_reg;
                mx_neg = an_neg_reg;
                priority case (op_reg)
                    rau_pkg::OP_MUL:
                    begin
                        my_mag = bn_reg;
                        my_neg = bn_neg_reg;
                    end
                    rau_pkg::OP_REDUCE:
                    begin
                        my_mag = WIDTH'(1);
                        my_neg = 1'b0;
                    end
                    default:
                    begin
                        my_mag = bd_reg;
                        my_neg = bd_neg_reg;
                    end
                endcase
            end
            2'd1:
            begin
                if (op_reg == rau_pkg::OP_ADD || op_reg == rau_pkg::OP_SUB)
                begin
                    mx_mag = ad_reg;
                    mx_neg = ad_neg_reg;
                    my_mag = bn_reg;
                    my_neg = bn_neg_reg;
                end
                else
                begin
                    mx_mag = '0;
                    mx_neg = 1'b0;
                    my_mag = '0;
                    my_neg = 1'b0;
                end
            end
            default:
            begin
                mx_mag = ad_reg;
                mx_neg = ad_neg_reg;
                priority case (op_reg)
                    rau_pkg::OP_DIV:
                    begin
                        my_mag = bn_reg;
                        my_neg = bn_neg_reg;
                    end
                    rau_pkg::OP_REDUCE:
                    begin
                        my_mag = WIDTH'(1);
                        my_neg = 1'b0;
                    end
                    default:
                    begin
                        my_mag = bd_reg;
                        my_neg = bd_neg_reg;
                    end
                endcase
            end
        endcase
    end

    assign prod     = DW'(mx_mag) * DW'(my_mag);
    assign prod_neg = (prod != '0) && (mx_neg ^ my_neg);

    // ------------------------------------------------------------------------
    // Shared adder/subtractor operand selection
    // ------------------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            rau_pkg::S_ADD:
            begin
                alu_a   = {1'b0, n_reg};
                alu_b   = {1'b0, t_reg};
                alu_sub = n_neg_reg ^ t_neg_reg;
            end
            rau_pkg::S_GCD:
            begin
                alu_a   = {1'b0, v_reg};
                alu_b   = {1'b0, u_reg};
                alu_sub = 1'b1;
            end
            default:
            begin
                // divider trial subtract of the shifted remainder
                alu_a   = {rem_reg, q_reg[DW-1]};
                alu_b   = {1'b0, u_reg};
                alu_sub = 1'b1;
            end
        endcase
    end

    rau_alu #(
        .AW (AW)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .sum  (alu_sum),
        .cout (alu_cout)
    );

    // Restoring division step: carry out set means the trial fits
    assign q_shift  = {q_reg[DW-2:0], alu_cout};
    assign rem_step = alu_cout ? alu_sum[DW-1:0] : alu_a[DW-1:0];

    // Range check on the reduced fraction (rn in t_reg, rd in q_reg)
    assign res_neg = n_neg_reg ^ d_neg_reg;
    assign rd_big  = |q_reg[DW-1:WIDTH-1];
    assign rn_big  = |t_reg[DW-1:WIDTH-1];
    assign rn_over = res_neg ? (rn_big && (t_reg != HALF)) : rn_big;
    assign num_w   = res_neg ? (~t_reg[WIDTH-1:0] + 1'b1) : t_reg[WIDTH-1:0];

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        an_neg_next = an_neg_reg;
        ad_neg_next = ad_neg_reg;
        bn_neg_next = bn_neg_reg;
        bd_neg_next = bd_neg_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        t_next      = t_reg;
        n_neg_next  = n_neg_reg;
        d_neg_next  = d_neg_reg;
        t_neg_next  = t_neg_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            rau_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next     = req.opcode;
                    an_next     = in_an;
                    ad_next     = in_ad;
                    bn_next     = in_bn;
                    bd_next     = in_bd;
                    an_neg_next = in_an_neg;
                    ad_neg_next = in_ad_neg;
                    bn_neg_next = in_bn_neg;
                    bd_neg_next = in_bd_neg;
                    cnt_next    = '0;
                    if (req.opcode == rau_pkg::OP_EQUAL)
                    begin
                        rsp_next          = '0;
                        rsp_next.is_equal = in_equal;
                        done_next         = 1'b1;
                    end
                    else if (req.opcode > rau_pkg::OP_EQUAL)
                    begin
                        // unused opcodes answer with an all-zero response
                        rsp_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = rau_pkg::S_MUL;
                    end
                end
            end

            rau_pkg::S_MUL:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        n_next     = prod;
                        n_neg_next = prod_neg;
                    end
                    2'd1:
                    begin
                        t_next     = prod;
                        t_neg_next = prod_neg;
                    end
                    default:
                    begin
                        d_next     = prod;
                        d_neg_next = prod_neg;
                    end
                endcase
                if (cnt_reg == CNT_W'(2))
                begin
                    cnt_next   = '0;
                    state_next = rau_pkg::S_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            rau_pkg::S_ADD:
            begin
                if (!alu_sub)
                begin
                    n_next     = alu_sum[DW-1:0];
                    state_next = rau_pkg::S_CHECK;
                end
                else if (!alu_cout)
                begin
                    // larger magnitude goes to n, then subtract next cycle
                    n_next     = t_reg;
                    n_neg_next = t_neg_reg;
                    t_next     = n_reg;
                    t_neg_next = n_neg_reg;
                end
                else
                begin
                    n_next     = alu_sum[DW-1:0];
                    state_next = rau_pkg::S_CHECK;
                end
            end

            rau_pkg::S_CHECK:
            begin
                if (d_reg == '0)
                begin
                    // zero denominator: 1/0, or 0/0 when both parts are zero
                    rsp_next         = '0;
                    rsp_next.res_num = (n_reg != '0) ? 32'sd1 : 32'sd0;
                    rsp_next.status  = rau_pkg::STAT_ZERO_DEN;
                    done_next        = 1'b1;
                    state_next       = rau_pkg::S_IDLE;
                end
                else if (n_reg == '0)
                begin
                    rsp_next         = '0;
                    rsp_next.res_den = 31'd1;
                    rsp_next.status  = rau_pkg::STAT_OK;
                    done_next        = 1'b1;
                    state_next       = rau_pkg::S_IDLE;
                end
                else
                begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    state_next = rau_pkg::S_TWOS;
                end
            end

            rau_pkg::S_TWOS:
            begin
                // drop common factors of two from the pair and the fraction
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else
                begin
                    state_next = rau_pkg::S_UODD;
                end
            end

            rau_pkg::S_UODD:
            begin
                if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else
                begin
                    state_next = rau_pkg::S_GCD;
                end
            end

            rau_pkg::S_GCD:
            begin
                priority if (v_reg == '0)
                begin
                    // u now holds the odd part of the GCD
                    rem_next   = '0;
                    q_next     = n_reg;
                    cnt_next   = '0;
                    state_next = rau_pkg::S_DIVN;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!alu_cout)
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
                else
                begin
                    v_next = alu_sum[DW-1:0];
                end
            end

            rau_pkg::S_DIVN:
            begin
                rem_next = rem_step;
                q_next   = q_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    // hold the reduced numerator, start on the denominator
                    t_next     = q_shift;
                    q_next     = d_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = rau_pkg::S_DIVD;
                end
            end

            rau_pkg::S_DIVD:
            begin
                rem_next = rem_step;
                q_next   = q_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = rau_pkg::S_FIN;
                end
            end

            rau_pkg::S_FIN:
            begin
                rsp_next = '0;
                if (rd_big || rn_over)
                begin
                    rsp_next.status = rau_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    rsp_next.res_num = 32'(num_w);
                    rsp_next.res_den = 31'(q_reg[WIDTH-2:0]);
                    rsp_next.status  = rau_pkg::STAT_OK;
                end
                done_next  = 1'b1;
                state_next = rau_pkg::S_IDLE;
            end

            default:
            begin
                state_next = rau_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rau_pkg::S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        an_neg_reg <= an_neg_next;
        ad_neg_reg <= ad_neg_next;
        bn_neg_reg <= bn_neg_next;
        bd_neg_reg <= bd_neg_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        t_reg      <= t_next;
        n_neg_reg  <= n_neg_next;
        d_neg_reg  <= d_neg_next;
        t_neg_reg  <= t_neg_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        rsp_reg    <= rsp_next;
    end

    assign busy = (state_reg != rau_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* tb/tb_rational_arith_unit_core.sv */
// ============================================================================
// tb_rational_arith_unit_core - self-checking bench for the fraction unit
// Drives add, subtract, multiply, divide, reduce, equal and unused opcodes,
// first a directed set of edge cases and then weighted random requests under
// varying sender idling. A scoreboard predicts each response and compares it
// field by field as it arrives.
// ============================================================================
`timescale 1ns / 100ps

module tb_rational_arith_unit_core;

    localparam int W = rau_pkg::RAU_WIDTH;
    // Limit allows every request the longest GCD and division time plus the
    // longest sender gap, taken several times over
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_REQUESTS = 700;
    localparam int DRAIN_CYCLES = 400;

    // Opcodes the unit leaves undefined; they must answer with all zeros
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_NEG = 32'h8000_0000;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the reduced fraction for each accepted request and
    // checks responses in order against those predictions
    // ------------------------------------------------------------------------
    class fraction_scoreboard;

        typedef struct packed {
            logic        neg;
            logic [63:0] mag;
        } signmag_t;

        rau_pkg::rsp_t pending_results[$];
        int   errors;
        int   checked;
        int   zero_den_seen;
        int   overflow_seen;
        int   equal_hits;

        function new();
            errors = 0;
            checked = 0;
            zero_den_seen = 0;
            overflow_seen = 0;
            equal_hits = 0;
        endfunction

        function logic [63:0] field_mask();
            return (64'd1 << W) - 64'd1;
        endfunction

        // Take the low W bits of a field as sign and magnitude
        function signmag_t split_field(logic [31:0] f);
            signmag_t r;
            logic [63:0] v;
            v = {32'd0, f} & field_mask();
            r.neg = v[W-1];
            r.mag = r.neg ? ((~v + 64'd1) & field_mask()) : v;
            return r;
        endfunction

        function signmag_t sm_mul(signmag_t x, signmag_t y);
            signmag_t r;
            r.mag = x.mag * y.mag;
            r.neg = (r.mag != 64'd0) && (x.neg != y.neg);
            return r;
        endfunction

        function signmag_t sm_add(signmag_t x, signmag_t y);
            signmag_t r;
            if (x.neg == y.neg)
            begin
                r.mag = x.mag + y.mag;
                r.neg = x.neg;
            end
            else if (x.mag >= y.mag)
            begin
                r.mag = x.mag - y.mag;
                r.neg = x.neg;
            end
            else
            begin
                r.mag = y.mag - x.mag;
                r.neg = y.neg;
            end
            if (r.mag == 64'd0)
                r.neg = 1'b0;
            return r;
        endfunction

        function logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 64'd0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function rau_pkg::rsp_t fraction_result(rau_pkg::req_t r);
            rau_pkg::rsp_t p;
            signmag_t      an, ad, bn, bd, n, d;
            logic [63:0]   half, g, rn, rd, signed_rn;
            logic          neg;
            p = '0;
            half = 64'd1 << (W - 1);
            an = split_field(r.a_num);
            ad = split_field(r.a_den);
            bn = split_field(r.b_num);
            bd = split_field(r.b_den);
            case (r.opcode)
                rau_pkg::OP_ADD:
                begin
                    n = sm_add(sm_mul(an, bd), sm_mul(ad, bn));
                    d = sm_mul(ad, bd);
                end
                rau_pkg::OP_SUB:
                begin
                    bn.neg = !bn.neg;
                    n = sm_add(sm_mul(an, bd), sm_mul(ad, bn));
                    d = sm_mul(ad, bd);
                end
                rau_pkg::OP_MUL:
                begin
                    n = sm_mul(an, bn);
                    d = sm_mul(ad, bd);
                end
                rau_pkg::OP_DIV:
                begin
                    n = sm_mul(an, bd);
                    d = sm_mul(ad, bn);
                end
                rau_pkg::OP_REDUCE:
                begin
                    n = an;
                    d = ad;
                end
                rau_pkg::OP_EQUAL:
                begin
                    p.is_equal = (({32'd0, r.a_num ^ r.b_num} & field_mask()) == 64'd0) &&
                                 (({32'd0, r.a_den ^ r.b_den} & field_mask()) == 64'd0);
                    return p;
                end
                default:
                    return p;
            endcase
            g = euclid_gcd(n.mag, d.mag);
            if (g == 64'd0)
            begin
                p.status = rau_pkg::STAT_ZERO_DEN;
                return p;
            end
            rn = n.mag / g;
            rd = d.mag / g;
            if (rd == 64'd0)
            begin
                p.res_num = 32'sd1;
                p.status = rau_pkg::STAT_ZERO_DEN;
                return p;
            end
            neg = (rn != 64'd0) && (n.neg != d.neg);
            if (rd > half - 64'd1 || (neg ? rn > half : rn > half - 64'd1))
            begin
                p.status = rau_pkg::STAT_OVERFLOW;
                return p;
            end
            signed_rn = neg ? (~rn + 64'd1) : rn;
            p.res_num = signed_rn[31:0];
            p.res_den = rd[30:0];
            return p;
        endfunction

        function void note_request(rau_pkg::req_t r);
            pending_results.push_back(fraction_result(r));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0h expected %0h (response %0d)",
                     what, got, want, checked);
            errors++;
        endtask

        task check_response(rau_pkg::rsp_t got);
            rau_pkg::rsp_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("response with no request waiting", 64'(got.res_num), 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (got.res_num !== want.res_num)
                report_mismatch("res_num", 64'(got.res_num), 64'(want.res_num));
            if (got.res_den !== want.res_den)
                report_mismatch("res_den", 64'(got.res_den), 64'(want.res_den));
            if (got.is_equal !== want.is_equal)
                report_mismatch("is_equal", 64'(got.is_equal), 64'(want.is_equal));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (want.status == rau_pkg::STAT_ZERO_DEN)
                zero_den_seen++;
            if (want.status == rau_pkg::STAT_OVERFLOW)
                overflow_seen++;
            if (want.is_equal)
                equal_hits++;
            checked++;
        endtask

    endclass

    // ------------------------------------------------------------------------
    // Signals and the unit under test
    // ------------------------------------------------------------------------
    logic          clk;
    logic          rst_n;
    logic          start;
    rau_pkg::req_t req;
    logic          busy;
    logic          done;
    rau_pkg::rsp_t rsp;

    fraction_scoreboard sb;
    int cycles;
    int requests_sent;

    rational_arith_unit_core #(
        .WIDTH(W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard the whole run against a hung sequencer
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge, so values are those that the edge
    // captures. Check the response first: a new request can be taken at the
    // same edge that ends the done cycle, and its prediction is the younger.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
                sb.check_response(rsp);
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(req);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Draw one operand field: mostly small values so that reductions and
    // in-range results dominate, with wide, extreme and fully random values
    function logic [31:0] pick_field();
        int k;
        int sh;
        k = $urandom_range(0, 99);
        if (k < 40)
            return int'($urandom_range(0, 40)) - 20;
        else if (k < 60)
            return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
        else if (k < 85)
            return $urandom;
        sh = $urandom_range(0, 30);
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'd1;
            2: return ALL_ONE;
            3: return MAX_POS;
            4: return MIN_NEG;
            5: return 32'd1 << sh;
            default: return -(32'd1 << sh);
        endcase
    endfunction

    // Hold a request on the bus until the unit takes it, then idle the
    // sender for a while with the given likelihood. Leave start high when no
    // gap follows, so that the next request comes back to back.
    task send_request(input logic [2:0] op, input logic [31:0] an, input logic [31:0] ad,
                      input logic [31:0] bn, input logic [31:0] bd, input int idle_pct);
        int gap;
        req <= '{opcode: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            // Mostly short gaps that land early in the unit's work; now and
            // then a long one that outlasts it and leaves the unit idle
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(1, 6);
            start <= 1'b0;
            req <= {$urandom, $urandom, $urandom, $urandom, 3'($urandom)};
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task send_random(input int idle_pct);
        logic [2:0]  op;
        logic [31:0] an, ad, bn, bd;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 4)
            op = (k < 2) ? OP_SPARE_LO : OP_SPARE_HI;
        else
            op = 3'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_EQUAL));
        an = pick_field();
        ad = pick_field();
        bn = pick_field();
        bd = pick_field();
        // Give the equality test real hits: copy a, or only its numerator
        if (op == rau_pkg::OP_EQUAL)
        begin
            k = $urandom_range(0, 3);
            if (k < 2)
            begin
                bn = an;
                bd = ad;
            end
            else if (k == 2)
                bn = an;
        end
        send_request(op, an, ad, bn, bd, idle_pct);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        requests_sent = 0;
        rst_n = 1'b0;
        start <= 1'b0;
        req <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain arithmetic first
        send_request(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
        send_request(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 0);
        send_request(rau_pkg::OP_SUB, -32'd3, 32'd4, 32'd5, -32'd6, 0);
        send_request(rau_pkg::OP_MUL, 32'd2, 32'd3, -32'd9, 32'd4, 0);
        // Products at the extremes: one too wide, one that cancels to 1/1
        send_request(rau_pkg::OP_MUL, MIN_NEG, 32'd1, MIN_NEG, 32'd1, 0);
        send_request(rau_pkg::OP_MUL, MAX_POS, 32'd2, 32'd2, MAX_POS, 0);
        // Division by a zero fraction gives 1/0
        send_request(rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 0);
        send_request(rau_pkg::OP_DIV, -32'd7, 32'd3, -32'd14, 32'd9, 0);
        // Both parts zero
        send_request(rau_pkg::OP_DIV, 32'd0, 32'd0, 32'd0, 32'd0, 0);
        send_request(rau_pkg::OP_REDUCE, 32'd0, 32'd0, ALL_ONE, ALL_ONE, 0);
        // Signs cancel, or move to the numerator
        send_request(rau_pkg::OP_REDUCE, -32'd6, -32'd4, MAX_POS, MIN_NEG, 0);
        send_request(rau_pkg::OP_REDUCE, 32'd6, -32'd4, 32'd0, 32'd0, 0);
        // Zero numerator reduces to 0/1; zero denominator to 1/0
        send_request(rau_pkg::OP_REDUCE, 32'd0, -32'd7, 32'd1, 32'd1, 0);
        send_request(rau_pkg::OP_REDUCE, -32'd5, 32'd0, 32'd1, 32'd1, 0);
        // Field-width limits: most negative fits, its negation and a
        // denominator of 2^(W-1) do not
        send_request(rau_pkg::OP_REDUCE, MIN_NEG, 32'd1, 32'd0, 32'd0, 0);
        send_request(rau_pkg::OP_REDUCE, MIN_NEG, ALL_ONE, 32'd0, 32'd0, 0);
        send_request(rau_pkg::OP_REDUCE, 32'd1, MIN_NEG, 32'd0, 32'd0, 0);
        send_request(rau_pkg::OP_REDUCE, MAX_POS, MAX_POS, 32'd0, 32'd0, 0);
        send_request(rau_pkg::OP_ADD, MAX_POS, 32'd1, MAX_POS, 32'd1, 0);
        send_request(rau_pkg::OP_ADD, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, 0);
        // Equality compares raw fields, so 3/4 and 6/8 differ
        send_request(rau_pkg::OP_EQUAL, 32'd3, 32'd4, 32'd3, 32'd4, 0);
        send_request(rau_pkg::OP_EQUAL, 32'd3, 32'd4, 32'd6, 32'd8, 0);
        send_request(rau_pkg::OP_EQUAL, ALL_ONE, ALL_ONE, ALL_ONE, ALL_ONE, 0);
        // Spare opcodes answer with zeros
        send_request(OP_SPARE_LO, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 0);
        send_request(OP_SPARE_HI, MIN_NEG, MIN_NEG, ALL_ONE, ALL_ONE, 0);

        // Random: a back-to-back stretch, then heavy and light sender idling
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i < RANDOM_REQUESTS / 3)
                send_random(0);
            else if (i < 2 * RANDOM_REQUESTS / 3)
                send_random(54);
            else
                send_random(22);
        end
        start <= 1'b0;

        // Drain: wait for every prediction to be matched, then allow a
        // request's worth of cycles for anything stray
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d requests and %0d responses in %0d cycles",
                 requests_sent, sb.checked, cycles);
        $display("Zero-denominator results %0d, too-wide results %0d, equal hits %0d",
                 sb.zero_den_seen, sb.overflow_seen, sb.equal_hits);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* rational_arith_unit_core.f */
sv/rau_pkg.sv
sv/rau_alu.sv
sv/rational_arith_unit_core.sv
tb/tb_rational_arith_unit_core.sv
